>>> rtl/dtp_pkg.sv
package dtp_pkg;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int FIELD_W = 7;
    localparam int ADD_W   = 32;
    localparam int DIV_W   = ADD_W + 1;
    localparam int REM_W   = 7;
    localparam int CNT_W   = 2;
    localparam int DAYS_W  = 16;

    // divide unit widths: operand after the power-of-two pre-shift, reciprocal, product
    localparam int SCALE_W  = 31;
    localparam int RECIP_W  = 30;
    localparam int PROD_W   = SCALE_W + RECIP_W;
    localparam int RECIP_SH = 31;

    // calendar constants
    localparam logic [YEAR_W-1:0]  YEAR_MAX     = 14'd9999;
    localparam logic [REM_W-1:0]   SEC_PER_MIN  = 7'd60;
    localparam logic [REM_W-1:0]   MIN_PER_HOUR = 7'd60;
    localparam logic [REM_W-1:0]   HOUR_PER_DAY = 7'd24;
    localparam logic [REM_W-1:0]   YEAR_PER_CEN = 7'd100;
    localparam logic [FIELD_W-1:0] MONTH_DEC    = 7'd12;
    localparam logic [CNT_W-1:0]   DIV_STEPS    = CNT_W'(3);

    // odd factors of the divisors and their scaled reciprocals
    localparam logic [REM_W-1:0]   BASE_CEN   = YEAR_PER_CEN >> 2;
    localparam logic [REM_W-1:0]   BASE_SIXTY = SEC_PER_MIN >> 2;
    localparam logic [REM_W-1:0]   BASE_DAY   = HOUR_PER_DAY >> 3;
    localparam logic [RECIP_W-1:0] RECIP_CEN   = RECIP_W'((64'd1 << RECIP_SH) / BASE_CEN);
    localparam logic [RECIP_W-1:0] RECIP_SIXTY = RECIP_W'((64'd1 << RECIP_SH) / BASE_SIXTY);
    localparam logic [RECIP_W-1:0] RECIP_DAY   = RECIP_W'((64'd1 << RECIP_SH) / BASE_DAY);

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [FIELD_W-1:0] start_month;
        logic [FIELD_W-1:0] start_day;
        logic [FIELD_W-1:0] start_hour;
        logic [FIELD_W-1:0] start_minute;
        logic [FIELD_W-1:0] start_second;
        logic [ADD_W-1:0]   add_seconds;
    } t_req;

    typedef struct packed {
        logic              error_flag;
        logic [YEAR_W-1:0] end_year;
        logic [3:0]        end_month;
        logic [4:0]        end_day;
        logic [4:0]        end_hour;
        logic [5:0]        end_minute;
        logic [5:0]        end_second;
    } t_rsp;

    typedef enum logic [1:0] {
        DIV_CENTURY,
        DIV_SIXTY,
        DIV_DAY
    } t_div_op;

    typedef struct packed {
        logic    load;
        t_div_op op;
    } t_div_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT,
        ST_CHECK,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_YEAR,
        PH_SEC,
        PH_MIN,
        PH_HOUR
    } t_phase;

    // leap year from year mod 100 and century mod 4
    function automatic logic is_leap(input logic [REM_W-1:0] yr_lo, input logic [1:0] cent);
        is_leap = ((yr_lo[1:0] == 2'd0) && (yr_lo != '0)) ||
                  ((yr_lo == '0) && (cent == 2'd0));
    endfunction

    // days in month, month codes outside 1..12 read as 31
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        month_len = len;
    endfunction

endpackage

>>> rtl/dtp_div.sv
module dtp_div
    import dtp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_ctrl        i_ctrl,
    input  logic [DIV_W-1:0] i_dividend,
    output logic [DIV_W-1:0] o_quot,
    output logic [REM_W-1:0] o_rem,
    output logic             o_done
);

    localparam logic [CNT_W-1:0] STEP_MUL = DIV_STEPS;
    localparam logic [CNT_W-1:0] STEP_REM = CNT_W'(2);
    localparam logic [CNT_W-1:0] STEP_FIX = CNT_W'(1);

    logic [CNT_W-1:0]   r_cnt;
    t_div_op            r_op;
    logic [SCALE_W-1:0] r_y;
    logic [2:0]         r_lo;
    logic [DIV_W-1:0]   r_q;
    logic [REM_W-1:0]   r_r;

    logic [SCALE_W-1:0] w_y;
    logic [2:0]         w_lo;
    logic [REM_W-1:0]   w_base;
    logic [RECIP_W-1:0] w_recip;
    logic [PROD_W-1:0]  w_prod;
    logic [REM_W-1:0]   w_qd;

    // split off the power-of-two factor of the divisor
    always_comb begin
        if (i_ctrl.op == DIV_DAY) begin
            w_y  = {1'b0, i_dividend[DIV_W-1:3]};
            w_lo = i_dividend[2:0];
        end else begin
            w_y  = i_dividend[DIV_W-1:2];
            w_lo = {1'b0, i_dividend[1:0]};
        end
    end

    // odd factor and its reciprocal
    always_comb begin
        unique case (r_op)
            DIV_CENTURY: begin
                w_base  = BASE_CEN;
                w_recip = RECIP_CEN;
            end
            DIV_SIXTY: begin
                w_base  = BASE_SIXTY;
                w_recip = RECIP_SIXTY;
            end
            DIV_DAY: begin
                w_base  = BASE_DAY;
                w_recip = RECIP_DAY;
            end
            default: begin
                w_base  = BASE_DAY;
                w_recip = RECIP_DAY;
            end
        endcase
    end

    // quotient estimate is low by at most one; remainder needs only the low bits
    always_comb begin
        w_prod = PROD_W'(r_y) * PROD_W'(w_recip);
        w_qd   = r_q[REM_W-1:0] * w_base;
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.load) begin
            r_cnt <= DIV_STEPS;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // multiply, remainder, then one correction step
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_op <= i_ctrl.op;
            r_y  <= w_y;
            r_lo <= w_lo;
        end else if (r_cnt == STEP_MUL) begin
            r_q <= DIV_W'(w_prod[PROD_W-1:RECIP_SH]);
        end else if (r_cnt == STEP_REM) begin
            r_r <= r_y[REM_W-1:0] - w_qd;
        end else if ((r_cnt == STEP_FIX) && (r_r >= w_base)) begin
            r_q <= r_q + 1'b1;
            r_r <= r_r - w_base;
        end
    end

    assign o_quot = r_q;
    assign o_rem  = (r_op == DIV_DAY) ? {r_r[3:0], r_lo} : {r_r[4:0], r_lo[1:0]};
    assign o_done = (r_cnt == '0);

endmodule

>>> rtl/datetime_plus_seconds_core.sv
// channel  | direction | handshake            | payload
// request  | in        | i_valid / o_stall    | i_req (t_req)
// response | out       | o_valid / i_stall    | o_rsp (t_rsp)
//
// one request runs through accept, four divisions, check and hand-off, plus one walk
// step per month crossed and one for the last part month.
// the reciprocal-multiply divide unit is shared for year/100, seconds/60, minutes/60, hours/24.
// o_stall is high while a request is in work; the response register lets the next
// request in while a finished response is still stalled.
// reset (synchronous, active low) returns to idle with no response pending.
module datetime_plus_seconds_core
    import dtp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_o_valid, n_o_valid;
    t_rsp   r_rsp, n_rsp;

    logic [YEAR_W-1:0]  r_year, n_year;
    logic [FIELD_W-1:0] r_month, n_month;
    logic [FIELD_W-1:0] r_day, n_day;
    logic [FIELD_W-1:0] r_hour_in, n_hour_in;
    logic [FIELD_W-1:0] r_min_in, n_min_in;
    logic [DIV_W-1:0]   r_work, n_work;
    logic [DAYS_W-1:0]  r_days, n_days;
    logic [REM_W-1:0]   r_yr_lo, n_yr_lo;
    logic [1:0]         r_cent, n_cent;
    logic               r_err, n_err;
    logic [5:0]         r_sec, n_sec;
    logic [5:0]         r_min, n_min;
    logic [4:0]         r_hour, n_hour;

    t_div_ctrl          w_div_ctrl;
    logic [DIV_W-1:0]   w_dividend;
    logic [DIV_W-1:0]   w_quot;
    logic [REM_W-1:0]   w_rem;
    logic               w_div_done;
    logic               w_leap;
    logic [4:0]         w_ml;
    logic [DAYS_W:0]    w_sum;
    logic [DAYS_W-1:0]  w_skip;
    logic               w_out_free;

    // shared divider
    dtp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (w_dividend),
        .o_quot     (w_quot),
        .o_rem      (w_rem),
        .o_done     (w_div_done)
    );

    // divider operand select
    always_comb begin
        w_div_ctrl.load = (r_state == ST_LOAD);
        unique case (r_phase)
            PH_YEAR: w_div_ctrl.op = DIV_CENTURY;
            PH_SEC:  w_div_ctrl.op = DIV_SIXTY;
            PH_MIN:  w_div_ctrl.op = DIV_SIXTY;
            PH_HOUR: w_div_ctrl.op = DIV_DAY;
            default: w_div_ctrl.op = DIV_DAY;
        endcase
        w_dividend = (r_phase == PH_YEAR) ? DIV_W'(r_year) : r_work;
    end

    // calendar helpers for the current month
    always_comb begin
        w_leap = is_leap(r_yr_lo, r_cent);
        w_ml   = month_len(r_month[3:0], w_leap);
        w_sum  = {1'b0, r_days} + (DAYS_W+1)'(r_day);
        w_skip = DAYS_W'(w_ml) - DAYS_W'(r_day) + DAYS_W'(1);
    end

    assign w_out_free = !r_o_valid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_WAIT;
            ST_WAIT: begin
                if (w_div_done) n_state = (r_phase == PH_HOUR) ? ST_CHECK : ST_LOAD;
            end
            ST_CHECK: n_state = ST_WALK;
            ST_WALK: begin
                if (r_err || (r_days == '0)) n_state = ST_DONE;
            end
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_phase   = r_phase;
        n_year    = r_year;
        n_month   = r_month;
        n_day     = r_day;
        n_hour_in = r_hour_in;
        n_min_in  = r_min_in;
        n_work    = r_work;
        n_days    = r_days;
        n_yr_lo   = r_yr_lo;
        n_cent    = r_cent;
        n_err     = r_err;
        n_sec     = r_sec;
        n_min     = r_min;
        n_hour    = r_hour;
        n_rsp     = r_rsp;
        n_o_valid = r_o_valid && i_stall;
        unique case (r_state)
            ST_IDLE: begin
                // capture request
                if (i_valid) begin
                    n_year    = i_req.start_year;
                    n_month   = i_req.start_month;
                    n_day     = i_req.start_day;
                    n_hour_in = i_req.start_hour;
                    n_min_in  = i_req.start_minute;
                    n_work    = DIV_W'(i_req.add_seconds) + DIV_W'(i_req.start_second);
                    n_phase   = PH_YEAR;
                    n_err     = 1'b0;
                end
            end
            ST_WAIT: begin
                // collect quotient and remainder of the finished phase
                if (w_div_done) begin
                    unique case (r_phase)
                        PH_YEAR: begin
                            n_yr_lo = w_rem;
                            n_cent  = w_quot[1:0];
                            n_phase = PH_SEC;
                        end
                        PH_SEC: begin
                            n_sec   = w_rem[5:0];
                            n_work  = w_quot + DIV_W'(r_min_in);
                            n_phase = PH_MIN;
                        end
                        PH_MIN: begin
                            n_min   = w_rem[5:0];
                            n_work  = w_quot + DIV_W'(r_hour_in);
                            n_phase = PH_HOUR;
                        end
                        PH_HOUR: begin
                            n_hour  = w_rem[4:0];
                            n_days  = w_quot[DAYS_W-1:0];
                            n_phase = PH_YEAR;
                        end
                        default: n_phase = PH_YEAR;
                    endcase
                end
            end
            ST_CHECK: begin
                // start date validity
                n_err = (r_year > YEAR_MAX) || (r_month == '0) || (r_month > MONTH_DEC) ||
                        (r_day == '0) || (r_day > FIELD_W'(w_ml));
            end
            ST_WALK: begin
                // advance one month, or finish inside this month
                if (!r_err && (r_days != '0)) begin
                    if (w_sum > (DAYS_W+1)'(w_ml)) begin
                        n_days = r_days - w_skip;
                        n_day  = FIELD_W'(1);
                        if (r_month == MONTH_DEC) begin
                            n_month = FIELD_W'(1);
                            n_year  = r_year + 1'b1;
                            if (r_year >= YEAR_MAX) n_err = 1'b1;
                            if (r_yr_lo == YEAR_PER_CEN - 1'b1) begin
                                n_yr_lo = '0;
                                n_cent  = r_cent + 1'b1;
                            end else begin
                                n_yr_lo = r_yr_lo + 1'b1;
                            end
                        end else begin
                            n_month = r_month + 1'b1;
                        end
                    end else begin
                        n_day  = r_day + FIELD_W'(r_days);
                        n_days = '0;
                    end
                end
            end
            ST_DONE: begin
                // hand result to the response register
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_rsp     = '0;
                    if (r_err) begin
                        n_rsp.error_flag = 1'b1;
                    end else begin
                        n_rsp.end_year   = r_year;
                        n_rsp.end_month  = r_month[3:0];
                        n_rsp.end_day    = r_day[4:0];
                        n_rsp.end_hour   = r_hour;
                        n_rsp.end_minute = r_min;
                        n_rsp.end_second = r_sec;
                    end
                end
            end
            default: n_err = r_err;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_YEAR;
            r_o_valid <= 1'b0;
            r_err     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_o_valid <= n_o_valid;
            r_err     <= n_err;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_year    <= n_year;
        r_month   <= n_month;
        r_day     <= n_day;
        r_hour_in <= n_hour_in;
        r_min_in  <= n_min_in;
        r_work    <= n_work;
        r_days    <= n_days;
        r_yr_lo   <= n_yr_lo;
        r_cent    <= n_cent;
        r_sec     <= n_sec;
        r_min     <= n_min;
        r_hour    <= n_hour;
        r_rsp     <= n_rsp;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_o_valid;
    assign o_rsp   = r_rsp;

endmodule

>>> test/tb_datetime_plus_seconds_core.sv
`timescale 1ns / 1ps

module tb_datetime_plus_seconds_core
    import dtp_pkg::*;
();

    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 3;
    localparam int RANDOM_REQS  = 270;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 2500;
    localparam int DRAIN_CYCLES = 2000;
    localparam int IDLE_LIMIT   = 20000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_req i_req   = '0;
    logic o_stall;
    logic o_valid;
    t_rsp o_rsp;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    t_rsp want_rsp;

    int sent_cnt     = 0;
    int checked_cnt  = 0;
    int err_rsp_cnt  = 0;
    int mismatch_cnt = 0;
    int gap_left     = 0;
    int burst_left   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int idle_cycles  = 0;
    logic [15:0] stall_cyc = '0;

    datetime_plus_seconds_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // gregorian leap rule with the 400-year case
    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % YEAR_PER_CEN != 0)) || (y % 400 == 0);
    endfunction

    // month codes outside 1..12 count as 31 days
    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return leap_year(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // expected response for one request
    function automatic t_rsp add_seconds_to_date(input t_req r);
        longint unsigned secs;
        longint unsigned mins;
        longint unsigned hrs;
        longint unsigned days_left;
        int unsigned     yr;
        int unsigned     mon;
        int unsigned     dy;
        int unsigned     mlen;
        bit              bad;
        t_rsp            res;
        res  = '0;
        yr   = r.start_year;
        mon  = r.start_month;
        dy   = r.start_day;
        secs = longint'(r.start_second) + longint'(r.add_seconds);
        bad  = (yr > YEAR_MAX) || (mon < 1) || (mon > MONTH_DEC) || (dy < 1) ||
               (dy > days_in_month(yr, mon));
        // carry seconds into minutes, hours and whole days
        mins      = longint'(r.start_minute) + secs / SEC_PER_MIN;
        secs      = secs % SEC_PER_MIN;
        hrs       = longint'(r.start_hour) + mins / MIN_PER_HOUR;
        mins      = mins % MIN_PER_HOUR;
        days_left = hrs / HOUR_PER_DAY;
        hrs       = hrs % HOUR_PER_DAY;
        // walk forward one month at a time
        while (!bad && days_left > 0) begin
            mlen = days_in_month(yr, mon);
            if (days_left + dy > mlen) begin
                days_left = days_left - (mlen - dy + 1);
                dy  = 1;
                mon = mon + 1;
                if (mon > MONTH_DEC) begin
                    mon = 1;
                    yr  = yr + 1;
                    if (yr > YEAR_MAX)
                        bad = 1'b1;
                end
            end else begin
                dy        = dy + int'(days_left);
                days_left = 0;
            end
        end
        if (bad) begin
            res.error_flag = 1'b1;
        end else begin
            res.end_year   = yr[YEAR_W-1:0];
            res.end_month  = mon[3:0];
            res.end_day    = dy[4:0];
            res.end_hour   = hrs[4:0];
            res.end_minute = mins[5:0];
            res.end_second = secs[5:0];
        end
        return res;
    endfunction

    task automatic queue_req(input int unsigned y, input int unsigned mo, input int unsigned d,
                             input int unsigned h, input int unsigned mi, input int unsigned s,
                             input int unsigned add);
        t_req r;
        r.start_year   = YEAR_W'(y);
        r.start_month  = FIELD_W'(mo);
        r.start_day    = FIELD_W'(d);
        r.start_hour   = FIELD_W'(h);
        r.start_minute = FIELD_W'(mi);
        r.start_second = FIELD_W'(s);
        r.add_seconds  = ADD_W'(add);
        pending_reqs.push_back(r);
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // request driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_rsps.push_back(add_seconds_to_date(i_req));
                sent_cnt++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    i_req   <= pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // response stall pattern, with one long hold-off to back up the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            stall_cyc <= '0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else begin
            stall_cyc <= stall_cyc + 1'b1;
            if (!hold_done && sent_cnt >= HOLD_AFTER) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                i_stall   <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_stall   <= 1'b1;
            end else begin
                case (stall_cyc[9:8])
                    2'd0:    i_stall <= 1'b0;
                    2'd1:    i_stall <= ($urandom_range(0, 3) == 0);
                    2'd2:    i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= stall_cyc[0];
                endcase
            end
        end
    end

    // response checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: response with no request outstanding, got %p", $time, o_rsp);
                mismatch_cnt++;
            end else begin
                want_rsp = expected_rsps.pop_front();
                check_field("error_flag", want_rsp.error_flag, o_rsp.error_flag);
                check_field("end_year",   want_rsp.end_year,   o_rsp.end_year);
                check_field("end_month",  want_rsp.end_month,  o_rsp.end_month);
                check_field("end_day",    want_rsp.end_day,    o_rsp.end_day);
                check_field("end_hour",   want_rsp.end_hour,   o_rsp.end_hour);
                check_field("end_minute", want_rsp.end_minute, o_rsp.end_minute);
                check_field("end_second", want_rsp.end_second, o_rsp.end_second);
                checked_cnt++;
                if (want_rsp.error_flag)
                    err_rsp_cnt++;
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned yr;
        int unsigned mon;
        int unsigned dy;
        int unsigned hr;
        int unsigned mi;
        int unsigned sc;
        int unsigned add;
        int unsigned sel;

        // directed calendar corners
        queue_req(0, 1, 1, 0, 0, 0, 0);
        queue_req(9999, 12, 31, 23, 59, 59, 0);
        queue_req(9999, 12, 31, 23, 59, 59, 1);
        queue_req(16383, 1, 1, 0, 0, 0, 0);
        queue_req(2023, 0, 10, 0, 0, 0, 5);
        queue_req(2023, 13, 1, 0, 0, 0, 5);
        queue_req(2023, 127, 127, 0, 0, 0, 0);
        queue_req(2023, 5, 0, 0, 0, 0, 0);
        queue_req(2023, 4, 31, 0, 0, 0, 0);
        queue_req(1900, 2, 29, 0, 0, 0, 0);
        queue_req(2000, 2, 29, 0, 0, 0, 86400);
        queue_req(2024, 2, 28, 0, 0, 0, 86400);
        queue_req(2100, 2, 28, 0, 0, 0, 86400);
        queue_req(2023, 6, 15, 127, 127, 127, 0);
        queue_req(2023, 1, 1, 0, 0, 0, 32'hFFFF_FFFF);
        queue_req(0, 1, 1, 127, 127, 127, 32'hFFFF_FFFF);
        queue_req(9990, 1, 1, 0, 0, 0, 32'hFFFF_FFFF);
        queue_req(2023, 12, 31, 23, 59, 59, 1);
        queue_req(2023, 1, 31, 0, 0, 0, 86400);
        queue_req(1, 1, 1, 0, 0, 0, 59);
        queue_req(1, 1, 1, 0, 0, 0, 60);

        // random requests, mostly well formed dates
        repeat (RANDOM_REQS) begin
            if ($urandom_range(0, 6) == 0) begin
                queue_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                yr  = ($urandom_range(0, 7) == 0) ? $urandom_range(9900, 9999)
                                                  : $urandom_range(0, 9999);
                mon = $urandom_range(1, 12);
                dy  = ($urandom_range(0, 3) == 0) ? days_in_month(yr, mon)
                                                  : $urandom_range(1, days_in_month(yr, mon));
                if ($urandom_range(0, 1) == 0) begin
                    hr = $urandom_range(0, 23);
                    mi = $urandom_range(0, 59);
                    sc = $urandom_range(0, 59);
                end else begin
                    hr = $urandom_range(0, 127);
                    mi = $urandom_range(0, 127);
                    sc = $urandom_range(0, 127);
                end
                sel = $urandom_range(0, 9);
                if (sel < 3)
                    add = $urandom_range(0, 200000);
                else if (sel < 6)
                    add = $urandom_range(0, 32'h00FF_FFFF);
                else if (sel < 8)
                    add = $urandom_range(0, 32'h0FFF_FFFF);
                else
                    add = $urandom;
                queue_req(yr, mon, dy, hr, mi, sc, add);
            end
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request to be sent and answered
        while (pending_reqs.size() != 0 || i_valid || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests sent, %0d responses checked, %0d of them error responses",
                 sent_cnt, checked_cnt, err_rsp_cnt);
        $display("covered calendar corners, leap rules, year overflow, bad dates, %s",
                 "full 32-bit second counts and a long response hold-off");
        if (mismatch_cnt == 0 && expected_rsps.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/dtp_pkg.sv
rtl/dtp_div.sv
rtl/datetime_plus_seconds_core.sv
test/tb_datetime_plus_seconds_core.sv
